@@ hdl/tta_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle tangent accumulator package
// Shared types, codes and constants for the tangent accumulator and its parts.
// ----------------------------------------------------------------------------
package tta_pkg;

   // Request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // Result kinds
   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_TANGENT = 1'b1;

   // Shift-subtract divider sizing
   localparam int DIV_W  = 36;
   localparam int DIV_QW = 31;
   localparam int DIV_CW = 5;

   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] tex_u;
      logic signed [15:0] tex_v;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic               degenerate;
      logic [9:0]         vertex_out;
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
      logic               zero_length;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_CW-1:0] steps;
      logic [DIV_W-1:0]  rem_init;
      logic [DIV_W-1:0]  divisor;
      logic [DIV_QW-1:0] bits;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DIV_QW-1:0] quot;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED_Q,
      ST_RED_R,
      ST_LOAD,
      ST_VRD_A,
      ST_VRD_B,
      ST_VRD_C,
      ST_VRD_END,
      ST_DET_MUL,
      ST_DET_SUB,
      ST_NUM_MUL,
      ST_NUM_SUB,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_RD_ACC,
      ST_RD_CAP,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_QDIV_GO,
      ST_QDIV_WAIT,
      ST_RESULT
   } state_type;

endpackage

@@ hdl/tta_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tta_div.sv @@
// ----------------------------------------------------------------------------
// Shift-subtract divider
// Restoring division, one quotient bit per cycle, for unsigned operands.
// ----------------------------------------------------------------------------
module tta_div
   import tta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  divisor_ff;
   logic [DIV_QW-1:0] bits_ff;
   logic [DIV_QW-1:0] quot_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIV_W-1:0]  rem_sh;
   logic              fits;

   // The next dividend bit moves into the partial remainder.
   always_comb begin
      rem_sh = {rem_ff[DIV_W-2:0], bits_ff[DIV_QW-1]};
      fits   = (rem_sh >= divisor_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= cmd.rem_init;
         divisor_ff <= cmd.divisor;
         bits_ff    <= cmd.bits;
         quot_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? (rem_sh - divisor_ff) : rem_sh;
         bits_ff <= {bits_ff[DIV_QW-2:0], 1'b0};
         quot_ff <= {quot_ff[DIV_QW-2:0], fits};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

@@ hdl/triangle_tangent_accumulator.sv @@
// ----------------------------------------------------------------------------
// Triangle tangent accumulator
// Vertex store with per-vertex tangent accumulation and normalised readout.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A load writes a vertex's position
// and texture coordinate and clears its accumulator. A triangle request
// reads the three corners from the vertex memory one after the other, forms
// the UV determinant and the three tangent components, and adds the tangent
// to each corner's accumulator by a read, add and write back through the
// accumulator memory; most of its time goes to the shared shift-subtract
// divider, which divides the three components in turn; a component whose
// quotient would overflow is saturated instead. A degenerate triangle skips
// the division and the accumulation. A readout normalises the magnitudes by
// shifting, sums their squares, takes the square root and divides each
// component by it. The result register lets a finished result wait for its
// transfer while the block is already free to take the next request. Corner
// indices are reduced modulo VERTEX_DEPTH before use. Memory contents are
// undefined after reset, so a vertex must be loaded before it is used in a triangle or read out.
// ----------------------------------------------------------------------------
module triangle_tangent_accumulator
   import tta_pkg::*;
#(
   parameter int VERTEX_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int ADDR_W = $clog2(VERTEX_DEPTH);
   // Reciprocal for the exact modulo of a ten-bit index.
   localparam int RECIP  = (2**20 + VERTEX_DEPTH - 1) / VERTEX_DEPTH;

   state_type state_ff, state_in;

   req_type            req_ff;
   logic [9:0]         qc_ff  [3];
   logic [ADDR_W-1:0]  cor_ff [3];
   logic [1:0]         k_ff;
   logic [79:0]        pa_ff;
   logic signed [16:0] e1_ff [3];
   logic signed [16:0] e2_ff [3];
   logic signed [16:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [33:0] prod0_ff, prod1_ff;
   logic [33:0]        det_mag_ff;
   logic               det_neg_ff;
   logic               degen_ff;
   logic signed [34:0] num_ff;
   logic               tneg_ff;
   logic signed [31:0] t_ff [3];
   logic               cneg_ff [3];
   logic [31:0]        mag_ff [3];
   logic [31:0]        max_ff;
   logic               zero_ff;
   logic [63:0]        sq_ff, sum_ff, x_ff, r_ff, sqbit_ff;
   logic signed [15:0] tan_ff [3];
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   // Memory and divider connections
   logic              vtx_wr_en, vtx_rd_en, acc_wr_en, acc_rd_en;
   logic [ADDR_W-1:0] vtx_rd_addr, acc_addr;
   logic [79:0]       vtx_rd_data;
   logic [95:0]       acc_wr_data, acc_rd_data;
   div_cmd_type       div_cmd;
   div_rsp_type       div_rsp;

   // Combinational datapath
   logic               req_take, rsp_load;
   logic [29:0]        qprod [3];
   logic [26:0]        qd [3];
   logic signed [16:0] dpos [3];
   logic signed [16:0] du_d, dv_d;
   logic signed [16:0] e1_sel, e2_sel;
   logic signed [34:0] det_s;
   logic [33:0]        det_abs;
   logic [33:0]        num_abs;
   logic               ovf;
   logic signed [31:0] acc_old [3];
   logic signed [32:0] acc_sum [3];
   logic signed [31:0] acc_new [3];
   logic signed [31:0] comp [3];
   logic [31:0]        cmag [3];
   logic [31:0]        cmax;
   logic [31:0]        mag_sel;
   logic [63:0]        sq_trial;
   logic [31:0]        quot_t;
   logic [15:0]        quot_n;
   logic [31:0]        vtx_wide;
   logic [ADDR_W-1:0]  acc_idx;

   tta_ram #(.WIDTH(80), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vtx_wr_en),
      .wr_addr (cor_ff[0]),
      .wr_data ({req_ff.tex_v, req_ff.tex_u, req_ff.pos_z, req_ff.pos_y, req_ff.pos_x}),
      .rd_en   (vtx_rd_en),
      .rd_addr (vtx_rd_addr),
      .rd_data (vtx_rd_data)
   );

   tta_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_addr),
      .wr_data (acc_wr_data),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_addr),
      .rd_data (acc_rd_data)
   );

   tta_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Arithmetic
   // ---------------------------------------------------------------------
   always_comb begin
      qprod[0] = 30'(req_ff.corner_a) * 30'(RECIP);
      qprod[1] = 30'(req_ff.corner_b) * 30'(RECIP);
      qprod[2] = 30'(req_ff.corner_c) * 30'(RECIP);
      for (int i = 0; i < 3; i++) begin
         qd[i] = 27'(qc_ff[i]) * 27'(VERTEX_DEPTH);
      end

      // Deltas between the arriving corner and corner a.
      for (int i = 0; i < 3; i++) begin
         dpos[i] = 17'(signed'(vtx_rd_data[16*i +: 16]))
                   - 17'(signed'(pa_ff[16*i +: 16]));
      end
      du_d = 17'(signed'(vtx_rd_data[63:48])) - 17'(signed'(pa_ff[63:48]));
      dv_d = 17'(signed'(vtx_rd_data[79:64])) - 17'(signed'(pa_ff[79:64]));

      unique case (k_ff)
         2'd0: begin
            e1_sel  = e1_ff[0];
            e2_sel  = e2_ff[0];
            mag_sel = mag_ff[0];
         end
         2'd1: begin
            e1_sel  = e1_ff[1];
            e2_sel  = e2_ff[1];
            mag_sel = mag_ff[1];
         end
         2'd2: begin
            e1_sel  = e1_ff[2];
            e2_sel  = e2_ff[2];
            mag_sel = mag_ff[2];
         end
         default: begin
            e1_sel  = '0;
            e2_sel  = '0;
            mag_sel = '0;
         end
      endcase

      det_s   = 35'(prod0_ff) - 35'(prod1_ff);
      det_abs = det_s[34] ? 34'(-det_s) : 34'(det_s);
      num_abs = num_ff[34] ? 34'(-num_ff) : 34'(num_ff);
      // The quotient reaches 2^31 exactly when |num| >= |det| * 2^11.
      ovf     = ({11'b0, num_abs} >= {det_mag_ff, 11'b0});

      // Saturating accumulation of the triangle's tangent.
      for (int i = 0; i < 3; i++) begin
         acc_old[i] = signed'(acc_rd_data[32*i +: 32]);
         acc_sum[i] = 33'(acc_old[i]) + 33'(t_ff[i]);
         if (acc_sum[i][32] != acc_sum[i][31]) begin
            acc_new[i] = acc_sum[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            acc_new[i] = acc_sum[i][31:0];
         end
      end

      // Magnitudes of the accumulator being read out.
      for (int i = 0; i < 3; i++) begin
         comp[i] = signed'(acc_rd_data[32*i +: 32]);
         cmag[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
      end
      cmax = cmag[0];
      if (cmag[1] > cmax) begin
         cmax = cmag[1];
      end
      if (cmag[2] > cmax) begin
         cmax = cmag[2];
      end

      sq_trial = r_ff + sqbit_ff;
      quot_t   = 32'(div_rsp.quot);
      quot_n   = 16'(div_rsp.quot[14:0]);
      vtx_wide = 32'(cor_ff[0]);
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RED_Q;
            end
         end
         ST_RED_Q: state_in = ST_RED_R;
         ST_RED_R: begin
            unique case (req_ff.mode)
               MODE_LOAD: state_in = ST_LOAD;
               MODE_TRI:  state_in = ST_VRD_A;
               MODE_READ: state_in = ST_RD_ACC;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_LOAD:    state_in = ST_IDLE;
         ST_VRD_A:   state_in = ST_VRD_B;
         ST_VRD_B:   state_in = ST_VRD_C;
         ST_VRD_C:   state_in = ST_VRD_END;
         ST_VRD_END: state_in = ST_DET_MUL;
         ST_DET_MUL: state_in = ST_DET_SUB;
         ST_DET_SUB: state_in = (det_s == '0) ? ST_RESULT : ST_NUM_MUL;
         ST_NUM_MUL: state_in = ST_NUM_SUB;
         ST_NUM_SUB: state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            if (!ovf) begin
               state_in = ST_DIV_WAIT;
            end else begin
               state_in = (k_ff == 2'd2) ? ST_ACC_RD : ST_NUM_MUL;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (k_ff == 2'd2) ? ST_ACC_RD : ST_NUM_MUL;
            end
         end
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: state_in = (k_ff == 2'd2) ? ST_RESULT : ST_ACC_RD;
         ST_RD_ACC: state_in = ST_RD_CAP;
         ST_RD_CAP: state_in = (cmax == '0) ? ST_RESULT : ST_NORM;
         ST_NORM:   state_in = (max_ff[31:30] == 2'b00) ? ST_NORM : ST_SQ;
         ST_SQ:     state_in = (k_ff == 2'd3) ? ST_SQRT : ST_SQ;
         ST_SQRT:   state_in = sqbit_ff[0] ? ST_QDIV_GO : ST_SQRT;
         ST_QDIV_GO: state_in = ST_QDIV_WAIT;
         ST_QDIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (k_ff == 2'd2) ? ST_RESULT : ST_QDIV_GO;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control outputs: handshakes, memory ports and divider commands
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      req_take    = req_valid && !req_stall;
      rsp_load    = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
      vtx_wr_en   = (state_ff == ST_LOAD);
      vtx_rd_en   = 1'b0;
      vtx_rd_addr = cor_ff[0];
      acc_wr_en   = 1'b0;
      acc_rd_en   = 1'b0;
      acc_wr_data = '0;
      unique case (k_ff)
         2'd1:    acc_idx = cor_ff[1];
         2'd2:    acc_idx = cor_ff[2];
         default: acc_idx = cor_ff[0];
      endcase
      acc_addr    = cor_ff[0];
      div_cmd     = '0;

      unique case (state_ff)
         ST_LOAD: begin
            acc_wr_en = 1'b1;
         end
         ST_VRD_A: begin
            vtx_rd_en = 1'b1;
         end
         ST_VRD_B: begin
            vtx_rd_en   = 1'b1;
            vtx_rd_addr = cor_ff[1];
         end
         ST_VRD_C: begin
            vtx_rd_en   = 1'b1;
            vtx_rd_addr = cor_ff[2];
         end
         ST_DIV_GO: begin
            div_cmd.start    = !ovf;
            div_cmd.steps    = DIV_CW'(31);
            div_cmd.rem_init = DIV_W'(num_abs >> 11);
            div_cmd.divisor  = DIV_W'(det_mag_ff);
            div_cmd.bits     = {num_abs[10:0], 20'b0};
         end
         ST_ACC_RD: begin
            acc_rd_en = 1'b1;
            acc_addr  = acc_idx;
         end
         ST_ACC_WR: begin
            acc_wr_en   = 1'b1;
            acc_addr    = acc_idx;
            acc_wr_data = {acc_new[2], acc_new[1], acc_new[0]};
         end
         ST_RD_ACC: begin
            acc_rd_en = 1'b1;
         end
         ST_QDIV_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = DIV_CW'(15);
            div_cmd.rem_init = DIV_W'(mag_sel >> 1);
            div_cmd.divisor  = DIV_W'(r_ff[31:0]);
            div_cmd.bits     = {mag_sel[0], 30'b0};
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_DET_SUB, ST_RD_CAP: k_ff <= '0;
            ST_DIV_GO: begin
               if (ovf) begin
                  k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
               end
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
               end
            end
            ST_ACC_WR: k_ff <= k_ff + 2'd1;
            ST_NORM:   k_ff <= '0;
            ST_SQ:     k_ff <= k_ff + 2'd1;
            ST_SQRT:   k_ff <= '0;
            ST_QDIV_WAIT: begin
               if (div_rsp.done) begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end

      unique case (state_ff)
         ST_RED_Q: begin
            for (int i = 0; i < 3; i++) begin
               qc_ff[i] <= qprod[i][29:20];
            end
         end
         ST_RED_R: begin
            cor_ff[0] <= ADDR_W'(27'(req_ff.corner_a) - qd[0]);
            cor_ff[1] <= ADDR_W'(27'(req_ff.corner_b) - qd[1]);
            cor_ff[2] <= ADDR_W'(27'(req_ff.corner_c) - qd[2]);
         end
         ST_VRD_B: begin
            pa_ff <= vtx_rd_data;
         end
         ST_VRD_C: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= dpos[i];
            end
            du1_ff <= du_d;
            dv1_ff <= dv_d;
         end
         ST_VRD_END: begin
            for (int i = 0; i < 3; i++) begin
               e2_ff[i] <= dpos[i];
            end
            du2_ff <= du_d;
            dv2_ff <= dv_d;
         end
         ST_DET_MUL: begin
            prod0_ff <= 34'(du1_ff * dv2_ff);
            prod1_ff <= 34'(dv1_ff * du2_ff);
         end
         ST_DET_SUB: begin
            det_mag_ff <= det_abs;
            det_neg_ff <= det_s[34];
            degen_ff   <= (det_s == '0);
         end
         ST_NUM_MUL: begin
            prod0_ff <= 34'(e1_sel * dv2_ff);
            prod1_ff <= 34'(e2_sel * dv1_ff);
         end
         ST_NUM_SUB: begin
            num_ff <= 35'(prod0_ff) - 35'(prod1_ff);
         end
         ST_DIV_GO: begin
            tneg_ff <= num_ff[34] ^ det_neg_ff;
            if (ovf) begin
               t_ff[k_ff] <= (num_ff[34] ^ det_neg_ff) ? 32'sh8000_0000
                                                       : 32'sh7FFF_FFFF;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               t_ff[k_ff] <= tneg_ff ? signed'(-quot_t) : signed'(quot_t);
            end
         end
         ST_RD_CAP: begin
            for (int i = 0; i < 3; i++) begin
               cneg_ff[i] <= comp[i][31];
               mag_ff[i]  <= cmag[i];
               tan_ff[i]  <= '0;
            end
            max_ff  <= cmax;
            zero_ff <= (cmax == '0);
            sq_ff   <= '0;
            sum_ff  <= '0;
         end
         ST_NORM: begin
            if (max_ff[31:30] == 2'b00) begin
               max_ff <= {max_ff[30:0], 1'b0};
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= {mag_ff[i][30:0], 1'b0};
               end
            end
         end
         ST_SQ: begin
            sq_ff  <= 64'(mag_sel) * 64'(mag_sel);
            sum_ff <= sum_ff + sq_ff;
            if (k_ff == 2'd3) begin
               x_ff     <= sum_ff + sq_ff;
               r_ff     <= '0;
               sqbit_ff <= 64'h4000_0000_0000_0000;
            end
         end
         ST_SQRT: begin
            if (x_ff >= sq_trial) begin
               x_ff <= x_ff - sq_trial;
               r_ff <= (r_ff >> 1) + sqbit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            sqbit_ff <= sqbit_ff >> 2;
         end
         ST_QDIV_WAIT: begin
            if (div_rsp.done) begin
               tan_ff[k_ff] <= cneg_ff[k_ff] ? signed'(-quot_n) : signed'(quot_n);
            end
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_ff.vertex_out <= vtx_wide[9:0];
         if (req_ff.mode == MODE_READ) begin
            rsp_ff.result_kind <= KIND_TANGENT;
            rsp_ff.degenerate  <= 1'b0;
            rsp_ff.tangent_x   <= tan_ff[0];
            rsp_ff.tangent_y   <= tan_ff[1];
            rsp_ff.tangent_z   <= tan_ff[2];
            rsp_ff.zero_length <= zero_ff;
         end else begin
            rsp_ff.result_kind <= KIND_STATUS;
            rsp_ff.degenerate  <= degen_ff;
            rsp_ff.tangent_x   <= '0;
            rsp_ff.tangent_y   <= '0;
            rsp_ff.tangent_z   <= '0;
            rsp_ff.zero_length <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
